### hdl/bracket_pair_matcher_core_defines.svh
// Assertion macros for the file that checks this block.
`ifndef BRACKET_PAIR_MATCHER_CORE_DEFINES_SVH
`define BRACKET_PAIR_MATCHER_CORE_DEFINES_SVH

// The expression holds at every clock edge outside reset.
`define BPM_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BPM_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/bpm_pkg.sv
package bpm_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int CP_W  = 21;
    localparam int LOC_W = 32;
    localparam int NUM_IGNORE = 4;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_CLOSE,
        OP_DRAIN
    } bpm_op_t;

    typedef enum logic [1:0] {
        KIND_NOT_OPENED = 2'd0,
        KIND_NOT_CLOSED = 2'd1,
        KIND_OVERFLOW   = 2'd2
    } bpm_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IGNORE_A = 2'd0,
        REG_IGNORE_B = 2'd1,
        REG_IGNORE_C = 2'd2,
        REG_IGNORE_D = 2'd3
    } bpm_reg_t;

    typedef struct packed {
        bpm_op_t           op;
        logic [CP_W-1:0]   code_point;
        logic [CP_W-1:0]   mirror_point;
        logic [LOC_W-1:0]  location;
    } bpm_entry_t;

    typedef struct packed {
        logic [STACK_CW-1:0] stack_count;
        logic                draining;
    } bpm_back_status_t;

endpackage

### hdl/bpm_front.sv
module bpm_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpm_pkg::CP_W-1:0]           cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [bpm_pkg::CP_W-1:0]           s_code_point,
    input  logic [bpm_pkg::CP_W-1:0]           s_mirror_point,
    input  logic [bpm_pkg::LOC_W-1:0]          s_location_tag,
    input  logic                               q_full,
    output logic                               q_push,
    output bpm_pkg::bpm_entry_t                q_entry
);
    import bpm_pkg::*;

    logic [CP_W-1:0] ignore_reg [NUM_IGNORE];
    logic            ignored;
    logic            skip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_IGNORE; i++) begin
                ignore_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (bpm_reg_t'(cfg_index))
                REG_IGNORE_A: ignore_reg[0] <= cfg_wdata;
                REG_IGNORE_B: ignore_reg[1] <= cfg_wdata;
                REG_IGNORE_C: ignore_reg[2] <= cfg_wdata;
                REG_IGNORE_D: ignore_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        ignored = 1'b0;
        for (int i = 0; i < NUM_IGNORE; i++) begin
            if ((ignore_reg[i] != '0) &&
                ((s_code_point == ignore_reg[i]) || (s_mirror_point == ignore_reg[i]))) begin
                ignored = 1'b1;
            end
        end
    end

    always_comb begin
        q_entry.code_point   = s_code_point;
        q_entry.mirror_point = s_mirror_point;
        q_entry.location     = s_location_tag;
        skip                 = 1'b0;
        if (s_action) begin
            q_entry.op = OP_DRAIN;
        end else if (s_code_point < s_mirror_point) begin
            q_entry.op = OP_PUSH;
            skip       = ignored;
        end else begin
            q_entry.op = OP_CLOSE;
            skip       = ignored || (s_mirror_point == '0);
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && !skip;

endmodule

### hdl/bpm_queue.sv
module bpm_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  bpm_pkg::bpm_entry_t          push_entry,
    output logic                         full,
    output logic                         pop_valid,
    input  logic                         pop_ready,
    output bpm_pkg::bpm_entry_t          pop_entry,
    output logic [bpm_pkg::Q_CW-1:0]     level
);
    import bpm_pkg::*;

    bpm_entry_t        slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_CW-1:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == Q_CW'(Q_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];
    assign level     = count_reg;
    assign do_push   = push && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/bpm_back.sv
module bpm_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          op_valid,
    output logic                          op_ready,
    input  bpm_pkg::bpm_entry_t           op_entry,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_report_kind,
    output logic [bpm_pkg::CP_W-1:0]      m_report_char,
    output logic [bpm_pkg::LOC_W-1:0]     m_report_location,
    output logic                          m_last_report,
    output bpm_pkg::bpm_back_status_t     status
);
    import bpm_pkg::*;

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t                state_reg;
    logic [STACK_CW-1:0]   count_reg;
    logic [STACK_AW-1:0]   drain_idx_reg;
    logic                  m_valid_reg;
    logic [1:0]            kind_reg;
    logic [CP_W-1:0]       char_reg;
    logic [LOC_W-1:0]      loc_reg;
    logic                  last_reg;

    logic [CP_W-1:0]       stack_chars [STACK_DEPTH];
    logic [LOC_W-1:0]      stack_locs  [STACK_DEPTH];

    logic                  out_free;
    logic                  take_op;
    logic                  stack_full;
    logic                  do_push;
    logic [STACK_CW-1:0]   count_m1;
    logic [STACK_AW-1:0]   rd_addr;
    logic [CP_W-1:0]       rd_char;
    logic [LOC_W-1:0]      rd_loc;
    logic                  drain_last;
    logic                  close_match;
    logic                  out_load;

    assign out_free   = !m_valid_reg || m_ready;
    assign op_ready   = (state_reg == ST_RUN) && out_free;
    assign take_op    = op_valid && op_ready;
    assign stack_full = (count_reg == STACK_CW'(STACK_DEPTH));
    assign do_push    = take_op && (op_entry.op == OP_PUSH) && !stack_full;
    assign count_m1   = count_reg - 1'b1;
    assign rd_addr    = (state_reg == ST_DRAIN) ? drain_idx_reg : count_m1[STACK_AW-1:0];
    assign rd_char    = stack_chars[rd_addr];
    assign rd_loc     = stack_locs[rd_addr];
    assign drain_last = ({1'b0, drain_idx_reg} + 1'b1) == count_reg;
    assign close_match = (count_reg != '0) && (rd_char == op_entry.mirror_point);
    assign out_load   = (state_reg == ST_DRAIN) ? out_free :
                        (take_op && (((op_entry.op == OP_PUSH) && stack_full) ||
                                     ((op_entry.op == OP_CLOSE) && !close_match)));

    always_ff @(posedge aclk) begin
        if (do_push) begin
            stack_chars[count_reg[STACK_AW-1:0]] <= op_entry.code_point;
            stack_locs[count_reg[STACK_AW-1:0]]  <= op_entry.location;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            count_reg     <= '0;
            drain_idx_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_RUN: begin
                    if (take_op) begin
                        unique case (op_entry.op)
                            OP_PUSH: begin
                                if (stack_full) begin
                                    kind_reg    <= KIND_OVERFLOW;
                                    char_reg    <= op_entry.code_point;
                                    loc_reg     <= op_entry.location;
                                    last_reg    <= 1'b1;
                                end else begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            OP_CLOSE: begin
                                if (close_match) begin
                                    count_reg <= count_m1;
                                end else begin
                                    kind_reg    <= KIND_NOT_OPENED;
                                    char_reg    <= op_entry.code_point;
                                    loc_reg     <= op_entry.location;
                                    last_reg    <= 1'b1;
                                end
                            end
                            OP_DRAIN: begin
                                if (count_reg != '0) begin
                                    state_reg     <= ST_DRAIN;
                                    drain_idx_reg <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DRAIN: begin
                    if (out_free) begin
                        kind_reg    <= KIND_NOT_CLOSED;
                        char_reg    <= rd_char;
                        loc_reg     <= rd_loc;
                        last_reg    <= drain_last;
                        if (drain_last) begin
                            count_reg <= '0;
                            state_reg <= ST_RUN;
                        end else begin
                            drain_idx_reg <= drain_idx_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_RUN;
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_report_kind      = kind_reg;
    assign m_report_char      = char_reg;
    assign m_report_location  = loc_reg;
    assign m_last_report      = last_reg;
    assign status.stack_count = count_reg;
    assign status.draining    = (state_reg == ST_DRAIN);

endmodule

### hdl/bracket_pair_matcher_core.sv
// A beat that causes a report is queued, then sets the registered m_valid when taken.
// Throughput: one input beat per cycle while the four-entry queue has room.
// An end-of-chapter beat holds the stack engine until every stacked entry is reported.
// Reset (aresetn low, synchronous) clears the ignore registers, stack count and queue.
// Stack contents are not cleared; only entries below the stack count are read.
`include "bracket_pair_matcher_core_defines.svh"

module bracket_pair_matcher_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpm_pkg::CP_W-1:0]           cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [bpm_pkg::CP_W-1:0]           s_code_point,
    input  logic [bpm_pkg::CP_W-1:0]           s_mirror_point,
    input  logic [bpm_pkg::LOC_W-1:0]          s_location_tag,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_report_kind,
    output logic [bpm_pkg::CP_W-1:0]           m_report_char,
    output logic [bpm_pkg::LOC_W-1:0]          m_report_location,
    output logic                               m_last_report
);
    import bpm_pkg::*;

    logic              q_full;
    logic              q_push;
    bpm_entry_t        q_in;
    logic              op_valid;
    logic              op_ready;
    bpm_entry_t        op_entry;
    logic [Q_CW-1:0]   q_level;
    bpm_back_status_t  back_status;

    bpm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_code_point   (s_code_point),
        .s_mirror_point (s_mirror_point),
        .s_location_tag (s_location_tag),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_in)
    );

    bpm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop_valid  (op_valid),
        .pop_ready  (op_ready),
        .pop_entry  (op_entry),
        .level      (q_level)
    );

    bpm_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .op_valid          (op_valid),
        .op_ready          (op_ready),
        .op_entry          (op_entry),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_report_kind     (m_report_kind),
        .m_report_char     (m_report_char),
        .m_report_location (m_report_location),
        .m_last_report     (m_last_report),
        .status            (back_status)
    );

    `BPM_ASSERT_ALWAYS(a_stack_bound, aclk, aresetn, back_status.stack_count <= STACK_CW'(STACK_DEPTH), "stack count beyond depth")
    `BPM_ASSERT_ALWAYS(a_queue_bound, aclk, aresetn, q_level <= Q_CW'(Q_DEPTH), "queue level beyond depth")
    `BPM_ASSERT_IMPLIES(a_single_last, aclk, aresetn, m_valid && (m_report_kind != KIND_NOT_CLOSED), m_last_report, "single report without last mark")
    `BPM_ASSERT_IMPLIES(a_drain_nonempty, aclk, aresetn, back_status.draining, back_status.stack_count != '0, "drain with empty stack")

endmodule

### sim/testbench.sv
module testbench;
    import bpm_pkg::*;

    localparam logic            ACT_CHAR      = 1'b0;
    localparam logic            ACT_DRAIN     = 1'b1;
    localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;
    localparam int              IDLE_PCT      = 37;
    localparam int              SETTLE_CYCLES = 48;
    localparam int              CYCLE_LIMIT   = 200000;

    typedef struct {
        bpm_kind_t        kind;
        logic [CP_W-1:0]  ch;
        logic [LOC_W-1:0] loc;
        logic             last;
    } bracket_report_t;

    class bracket_scoreboard;
        logic [CP_W-1:0]  ignore_cp [NUM_IGNORE];
        logic [CP_W-1:0]  open_chars [STACK_DEPTH];
        logic [LOC_W-1:0] open_locs [STACK_DEPTH];
        int               open_count;
        bracket_report_t  pending_reports [$];
        int               kind_count [3];
        int               errors;
        int               checked;

        function new();
            foreach (ignore_cp[i]) ignore_cp[i] = '0;
            open_count = 0;
            errors     = 0;
            checked    = 0;
            foreach (kind_count[i]) kind_count[i] = 0;
        endfunction

        function void set_ignore(int idx, logic [CP_W-1:0] value);
            ignore_cp[idx] = value;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        function void add_report(bpm_kind_t kind, logic [CP_W-1:0] ch,
                                 logic [LOC_W-1:0] loc, logic last);
            bracket_report_t r;
            r.kind = kind;
            r.ch   = ch;
            r.loc  = loc;
            r.last = last;
            pending_reports = {pending_reports, r};
            kind_count[kind]++;
        endfunction

        function bit is_ignored(logic [CP_W-1:0] cp, logic [CP_W-1:0] mir);
            foreach (ignore_cp[i]) begin
                if (ignore_cp[i] != 0 && (cp == ignore_cp[i] || mir == ignore_cp[i]))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Works out the reports one accepted input beat causes and updates the stack.
        function void predict_reports(logic act, logic [CP_W-1:0] cp,
                                      logic [CP_W-1:0] mir, logic [LOC_W-1:0] loc);
            if (act == ACT_DRAIN) begin
                for (int i = 0; i < open_count; i++)
                    add_report(KIND_NOT_CLOSED, open_chars[i], open_locs[i],
                               i == open_count - 1);
                open_count = 0;
            end else if (mir == 0 || is_ignored(cp, mir)) begin
                return;
            end else if (cp < mir) begin
                if (open_count >= STACK_DEPTH) begin
                    add_report(KIND_OVERFLOW, cp, loc, 1'b1);
                end else begin
                    open_chars[open_count] = cp;
                    open_locs[open_count]  = loc;
                    open_count++;
                end
            end else if (open_count > 0 && open_chars[open_count-1] == mir) begin
                open_count--;
            end else begin
                add_report(KIND_NOT_OPENED, cp, loc, 1'b1);
            end
        endfunction

        function void check_report(logic [1:0] kind, logic [CP_W-1:0] ch,
                                   logic [LOC_W-1:0] loc, logic last);
            bracket_report_t want;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report kind %0d char %h location %h",
                         $time, kind, ch, loc);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            checked++;
            if (want.kind !== kind) begin
                $display("%0t: report_kind expected %0d, got %0d", $time, want.kind, kind);
                errors++;
            end
            if (want.ch !== ch) begin
                $display("%0t: report_char expected %h, got %h", $time, want.ch, ch);
                errors++;
            end
            if (want.loc !== loc) begin
                $display("%0t: report_location expected %h, got %h", $time, want.loc, loc);
                errors++;
            end
            if (want.last !== last) begin
                $display("%0t: last_report expected %b, got %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [CP_W-1:0]      cfg_wdata      = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic                 s_action       = 1'b0;
    logic [CP_W-1:0]      s_code_point   = '0;
    logic [CP_W-1:0]      s_mirror_point = '0;
    logic [LOC_W-1:0]     s_location_tag = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [1:0]           m_report_kind;
    logic [CP_W-1:0]      m_report_char;
    logic [LOC_W-1:0]     m_report_location;
    logic                 m_last_report;

    bracket_scoreboard sb = new();
    bit                steady = 1'b0;
    int                beats_sent = 0;
    int                cycles = 0;

    bracket_pair_matcher_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_code_point      (s_code_point),
        .s_mirror_point    (s_mirror_point),
        .s_location_tag    (s_location_tag),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_report_kind     (m_report_kind),
        .m_report_char     (m_report_char),
        .m_report_location (m_report_location),
        .m_last_report     (m_last_report)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d reports still expected", $time, sb.pending());
            $display("** bracket_pair_matcher_core: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_report(m_report_kind, m_report_char, m_report_location, m_last_report);
    end

    task automatic write_reg(input bpm_reg_t idx, input logic [CP_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_ignore(int'(idx), value);
    endtask

    task automatic load_ignore_set(input logic [CP_W-1:0] a, input logic [CP_W-1:0] b,
                                   input logic [CP_W-1:0] c, input logic [CP_W-1:0] d);
        write_reg(REG_IGNORE_A, a);
        write_reg(REG_IGNORE_B, b);
        write_reg(REG_IGNORE_C, c);
        write_reg(REG_IGNORE_D, d);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_beat(input logic act, input logic [CP_W-1:0] cp,
                             input logic [CP_W-1:0] mir, input logic [LOC_W-1:0] loc);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_code_point   <= cp;
        s_mirror_point <= mir;
        s_location_tag <= loc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.predict_reports(act, cp, mir, loc);
        beats_sent++;
    endtask

    // The block may still hold queued beats after the last report, so allow extra cycles.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_opener(output logic [CP_W-1:0] cp, output logic [CP_W-1:0] mir);
        case ($urandom_range(11))
            0: begin cp = 21'h28;   mir = 21'h29;   end
            1: begin cp = 21'h5B;   mir = 21'h5D;   end
            2: begin cp = 21'h7B;   mir = 21'h7D;   end
            3: begin cp = 21'h3C;   mir = 21'h3E;   end
            4: begin cp = 21'hAB;   mir = 21'hBB;   end
            5: begin cp = 21'h2039; mir = 21'h203A; end
            6: begin cp = 21'h2045; mir = 21'h2046; end
            7: begin cp = 21'h300C; mir = 21'h300D; end
            default: begin
                cp  = CP_W'($urandom_range(0, CP_MAX - 1));
                mir = CP_W'($urandom_range(cp + 1, CP_MAX));
            end
        endcase
    endtask

    task automatic random_beat(input int close_pct);
        int unsigned      pick;
        int unsigned      k;
        logic             act;
        logic [CP_W-1:0]  cp;
        logic [CP_W-1:0]  mir;
        logic [CP_W-1:0]  top;
        logic [LOC_W-1:0] loc;
        act  = ACT_CHAR;
        loc  = $urandom;
        cp   = CP_W'($urandom_range(0, CP_MAX));
        mir  = CP_W'($urandom_range(0, CP_MAX));
        top  = (sb.open_count > 0) ? sb.open_chars[sb.open_count-1] : '0;
        pick = $urandom_range(99);
        if (pick < 4) begin
            act = ACT_DRAIN;
        end else if (pick < 9) begin
            // Unstructured noise: fields as drawn above.
        end else if (pick < 14) begin
            mir = '0;
        end else if (pick < 19) begin
            k = $urandom_range(NUM_IGNORE - 1);
            if (sb.ignore_cp[k] == 0)
                mir = '0;
            else if ($urandom_range(1) == 0)
                cp = sb.ignore_cp[k];
            else
                mir = sb.ignore_cp[k];
        end else if (pick < 25 || sb.open_count == 0 && pick < 25 + close_pct) begin
            mir = CP_W'($urandom_range(1, CP_MAX));
            if (mir == top)
                mir = (mir == CP_MAX) ? 21'h1 : mir + 21'd1;
            cp = CP_W'($urandom_range(mir, CP_MAX));
        end else if (pick < 25 + close_pct) begin
            mir = top;
            cp  = (CP_MAX - top < 4) ? top : top + CP_W'($urandom_range(0, 3));
        end else begin
            random_opener(cp, mir);
        end
        send_beat(act, cp, mir, loc);
    endtask

    task automatic random_phase(input int n_items, input int burst_len, input int close_pct);
        logic [CP_W-1:0] cp;
        logic [CP_W-1:0] mir;
        for (int i = 0; i < n_items; i++) begin
            if (i < burst_len) begin
                random_opener(cp, mir);
                send_beat(ACT_CHAR, cp, mir, $urandom);
            end else begin
                random_beat(close_pct);
            end
        end
        settle();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_ignore_set(21'hAB, CP_MAX, 21'h0, 21'h0);
        send_beat(ACT_DRAIN, CP_MAX, CP_MAX, 32'hFFFF_FFFF);
        send_beat(ACT_CHAR, 21'h41, 21'h0, 32'h1);
        send_beat(ACT_CHAR, 21'h0, 21'h0, 32'h0);
        send_beat(ACT_CHAR, 21'h29, 21'h28, 32'h100);
        send_beat(ACT_CHAR, 21'h28, 21'h29, 32'h0);
        send_beat(ACT_CHAR, 21'h5B, 21'h5D, 32'hFFFF_FFFF);
        send_beat(ACT_CHAR, 21'h29, 21'h28, 32'h200);
        send_beat(ACT_CHAR, 21'h5D, 21'h5B, 32'h300);
        send_beat(ACT_CHAR, 21'hAB, 21'hBB, 32'h400);
        send_beat(ACT_CHAR, 21'hBB, 21'hAB, 32'h500);
        send_beat(ACT_CHAR, 21'h7C, 21'h7C, 32'h600);
        send_beat(ACT_CHAR, 21'h0, CP_MAX - 1, 32'hA5A5_A5A5);
        send_beat(ACT_CHAR, CP_MAX - 1, 21'h0, 32'h700);
        send_beat(ACT_CHAR, 21'h1234, 21'h5678, 32'h800);
        send_beat(ACT_CHAR, 21'h1234, 21'h1234, 32'h900);
        send_beat(ACT_CHAR, CP_MAX, 21'h1, 32'hA00);
        send_beat(ACT_CHAR, 21'h5, CP_MAX, 32'hB00);
        send_beat(ACT_DRAIN, 21'h15555, 21'h0AAAA, 32'h5555_AAAA);
        settle();

        load_ignore_set(21'h0, 21'h28, 21'h2045, CP_MAX);
        random_phase(45, 0, 30);
        load_ignore_set(21'h5B, 21'h0, 21'hAB, 21'h1);
        random_phase(45, 34, 30);
        steady = 1'b1;
        load_ignore_set(21'h0, 21'h0, 21'h0, 21'h0);
        random_phase(45, 0, 35);
        steady = 1'b0;
        load_ignore_set(21'h300C, 21'hBB, CP_MAX, 21'h3C);
        random_phase(45, 34, 25);

        $display("Sent %0d beats across five ignore settings, including two deep stack fills.",
                 beats_sent);
        $display("Checked %0d reports: %0d not opened, %0d not closed, %0d overflow.",
                 sb.checked, sb.kind_count[KIND_NOT_OPENED], sb.kind_count[KIND_NOT_CLOSED],
                 sb.kind_count[KIND_OVERFLOW]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** bracket_pair_matcher_core: PASSED **");
        end else begin
            $display("** bracket_pair_matcher_core: FAILED **");
        end
        $finish;
    end
endmodule

### bracket_pair_matcher_core.f
+incdir+hdl
hdl/bpm_pkg.sv
hdl/bpm_front.sv
hdl/bpm_queue.sv
hdl/bpm_back.sv
hdl/bracket_pair_matcher_core.sv
sim/testbench.sv
